// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the letter translation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LTR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LTR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ltr_pkg.sv -----
// ----------------------------------------------------------------------------
// ltr_pkg
// Types, codes and defaults shared by the letter translation reachability
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ltr_pkg;

	localparam int ALPHABET_DEF = 26;
	localparam int LETTER_W     = 5;
	localparam int ACTION_W     = 2;

	// item action codes
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_EDGE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PAIR  = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [LETTER_W-1:0] from_letter;
		logic [LETTER_W-1:0] to_letter;
		logic                orig_present;
		logic                goal_present;
		logic                last;
	} item_t;

	typedef struct packed {
		logic match;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // input transfer this cycle
		logic step;     // one frontier expansion round
		logic resolve;  // search finished, fold result into word_ok
		logic emit;     // load the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_search;  // accepted item starts a reachability search
		logic pair_last;    // accepted item is the last letter pair
		logic search_done;  // frontier empty or round limit reached
		logic out_free;     // output register can take a new result
	} sts_t;

endpackage

// ----- src/ltr_item_if.sv -----
// ----------------------------------------------------------------------------
// ltr_item_if
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ltr_item_if;
	import ltr_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/ltr_result_if.sv -----
// ----------------------------------------------------------------------------
// ltr_result_if
// Valid/ready channel carrying one match result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ltr_result_if;
	import ltr_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/letter_translation_reachability.sv -----
// ----------------------------------------------------------------------------
// letter_translation_reachability
// Letter translation graph with reachability check of aligned word pairs.
//
//   Channel    Dir   Transfer moves
//   item_ch    in    action, from_letter, to_letter, orig_present,
//                    goal_present, last
//   result_ch  out   match (one per letter pair with last set)
//
// Clear and edge items are taken in IDLE. A letter pair that needs a search
// then runs rounds <= ALPHABET of the frontier
// expansion loop (one matrix union per cycle) and resolves; a last pair then waits in FINISH
// to load the output register. Reset clears the matrix at once, no sweep.
// A stalled result holds the output register; the block keeps taking items
// until a further result needs that register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module letter_translation_reachability #(
	parameter int ALPHABET = ltr_pkg::ALPHABET_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	ltr_item_if.sink         item_ch,
	ltr_result_if.source     result_ch
);
	import ltr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ltr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_ch.valid),
		.in_ready (item_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ltr_datapath #(
		.ALPHABET (ALPHABET)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (result_ch.ready),
		.out_valid (result_ch.valid),
		.result    (result_ch.data)
	);

	// checks
	`LTR_ASSERT_SAME(a_cmd_exclusive, clk, arst_n, 1'b1, $onehot0({cmd.accept, cmd.step, cmd.resolve, cmd.emit}), "commands overlap")
	`LTR_ASSERT_SAME(a_emit_free, clk, arst_n, cmd.emit, sts.out_free, "result loaded over a pending one")
	`LTR_ASSERT_NEXT(a_emit_valid, clk, arst_n, cmd.emit, result_ch.valid, "loaded result not offered")
	`LTR_ASSERT_SAME(a_step_live, clk, arst_n, cmd.step, !sts.search_done && !item_ch.ready, "search step after completion or while taking items")

endmodule

// ----- src/ltr_datapath.sv -----
// ----------------------------------------------------------------------------
// ltr_datapath
// Adjacency matrix, word status, frontier search registers and the output
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltr_datapath #(
	parameter int ALPHABET = ltr_pkg::ALPHABET_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ltr_pkg::item_t  item,
	input  ltr_pkg::cmd_t   cmd,
	output ltr_pkg::sts_t   sts,
	input  logic            out_ready,
	output logic            out_valid,
	output ltr_pkg::result_t result
);
	import ltr_pkg::*;

	localparam int CNT_W = $clog2(ALPHABET + 1);

	logic [ALPHABET-1:0] adj_q [ALPHABET];
	logic                nonempty_q;
	logic                word_ok_q;
	logic [ALPHABET-1:0] visited_q;
	logic [ALPHABET-1:0] frontier_q;
	logic [ALPHABET-1:0] dst_q;
	logic [CNT_W-1:0]    round_q;
	logic                out_valid_q;
	logic                match_q;

	logic [ALPHABET-1:0] src_oh;
	logic [ALPHABET-1:0] dst_oh;
	logic                both_in;
	logic                same_letter;
	logic                is_pair;
	logic [ALPHABET-1:0] next_reach;

	// letter decode: one-hot is zero for a letter outside the alphabet
	assign src_oh      = {{(ALPHABET-1){1'b0}}, 1'b1} << item.from_letter;
	assign dst_oh      = {{(ALPHABET-1){1'b0}}, 1'b1} << item.to_letter;
	assign both_in     = (|src_oh) && (|dst_oh);
	assign same_letter = (item.from_letter == item.to_letter);
	assign is_pair     = (item.action == ACT_PAIR);

	// one expansion round: union of rows selected by the frontier
	always_comb begin
		next_reach = '0;
		for (int k = 0; k < ALPHABET; k++) begin
			if (frontier_q[k]) begin
				next_reach = next_reach | adj_q[k];
			end
		end
	end

	// status to the controller
	always_comb begin
		sts.need_search = is_pair && item.orig_present && item.goal_present &&
			!same_letter && both_in;
		sts.pair_last   = is_pair && item.last;
		sts.search_done = (frontier_q == '0) || (round_q == CNT_W'(ALPHABET));
		sts.out_free    = !out_valid_q || out_ready;
	end

	// adjacency matrix and table flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ALPHABET; r++) begin
				adj_q[r] <= '0;
			end
			nonempty_q <= 1'b0;
		end else if (cmd.accept) begin
			if (item.action == ACT_CLEAR) begin
				for (int r = 0; r < ALPHABET; r++) begin
					adj_q[r] <= '0;
				end
				nonempty_q <= 1'b0;
			end else if (item.action == ACT_EDGE && both_in) begin
				for (int r = 0; r < ALPHABET; r++) begin
					if (src_oh[r]) begin
						adj_q[r] <= adj_q[r] | dst_oh;
					end
				end
				nonempty_q <= 1'b1;
			end
		end
	end

	// running word status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_ok_q <= 1'b1;
		end else if (cmd.accept) begin
			if (item.action == ACT_CLEAR) begin
				word_ok_q <= 1'b1;
			end else if (is_pair) begin
				if (item.orig_present && item.goal_present) begin
					// different letters with one outside the alphabet never match
					if (!same_letter && !both_in) begin
						word_ok_q <= 1'b0;
					end
				end else if (item.orig_present || item.goal_present) begin
					word_ok_q <= 1'b0;
				end
			end
		end else if (cmd.resolve) begin
			if ((visited_q & dst_q) == '0) begin
				word_ok_q <= 1'b0;
			end
		end else if (cmd.emit) begin
			word_ok_q <= 1'b1;
		end
	end

	// frontier search registers
	always_ff @(posedge clk) begin
		if (cmd.accept && sts.need_search) begin
			visited_q  <= src_oh;
			frontier_q <= src_oh;
			dst_q      <= dst_oh;
			round_q    <= '0;
		end else if (cmd.step) begin
			frontier_q <= next_reach & ~visited_q;
			visited_q  <= visited_q | next_reach;
			round_q    <= round_q + CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			match_q <= word_ok_q && nonempty_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result.match = match_q;

endmodule

// ----- src/ltr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ltr_ctrl
// Sequencer: takes items, runs the frontier search, hands the match bit to
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ltr_pkg::sts_t sts,
	output ltr_pkg::cmd_t cmd
);
	import ltr_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       fin_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.need_search) begin
						state_d = ST_SEARCH;
					end else if (sts.pair_last) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SEARCH: begin
				if (sts.search_done) begin
					cmd.resolve = 1'b1;
					state_d     = fin_q ? ST_FINISH : ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register and pending-last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				fin_q <= sts.pair_last;
			end
		end
	end

endmodule
